>>> src/mhpq_pkg.sv
// Shared widths and codes for the max-heap priority queue.
// No dependencies; imported by the top level and its checker.
package mhpq_pkg;

   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef logic [STATUS_W-1:0] status_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_EMPTY = 2'd2;

endpackage

>>> src/max_heap_priority_queue.sv
// Binary max-heap priority queue: heap memory, sift sequencer, shared comparator.
// Depends on mhpq_pkg.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   request | req_valid req_stall req_operation req_value   | in
//   result  | rsp_valid rsp_stall rsp_status                | out
//           | rsp_removed_value rsp_entry_count             |
//
// One request at a time; req_stall is high from acceptance until the result is loaded.
// Insert: each level climbed reads the parent, then compares and writes.
// Remove: read root, last entry; per level, read left then right child if any, compare.
// The sequencing is set by the heap memory (one write and one registered read a cycle).
// Full insert and empty remove go straight to the result. Synchronous reset empties the heap;
// the memory itself is not cleared. A stalled result holds while the next request runs.
module max_heap_priority_queue #(
   parameter int CAPACITY = 127
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic signed [mhpq_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mhpq_pkg::status_type                rsp_status,
   output logic signed [mhpq_pkg::VALUE_W-1:0] rsp_removed_value,
   output logic        [mhpq_pkg::COUNT_W-1:0] rsp_entry_count
);
   import mhpq_pkg::*;

   // positions 1..CAPACITY; count holds 0..CAPACITY
   localparam int AW       = $clog2(CAPACITY + 1);
   localparam int MemDepth = 1 << AW;
   localparam int CntXW    = (AW > COUNT_W) ? AW : COUNT_W;
   localparam logic [AW-1:0] Cap  = AW'(CAPACITY);
   localparam logic [AW-1:0] Root = AW'(1);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_UP_RD   = 4'd1;
   localparam logic [3:0] S_UP_CMP  = 4'd2;
   localparam logic [3:0] S_FIN_WR  = 4'd3;
   localparam logic [3:0] S_RM_LAST = 4'd4;
   localparam logic [3:0] S_RM_SET  = 4'd5;
   localparam logic [3:0] S_DN_RDL  = 4'd6;
   localparam logic [3:0] S_DN_RDR  = 4'd7;
   localparam logic [3:0] S_DN_CMP  = 4'd8;
   localparam logic [3:0] S_DONE    = 4'd9;

   // heap memory: one write and one registered read a cycle
   logic [VALUE_W-1:0] heap_mem [0:MemDepth-1];
   logic [VALUE_W-1:0] rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;

   logic [3:0]         state_ff, state_in;
   logic [AW-1:0]      count_ff, count_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [VALUE_W-1:0] moving_ff, moving_in;   // value being sifted
   logic [VALUE_W-1:0] cand_ff, cand_in;       // larger of left child and moving value
   logic               left_win_ff, left_win_in;
   status_type         status_ff, status_in;
   logic [VALUE_W-1:0] removed_ff, removed_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0] rsp_removed_ff, rsp_removed_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // shared comparator
   logic [VALUE_W-1:0] cmp_a, cmp_b;
   logic               cmp_gt;

   logic [AW:0]        left_pos, right_pos, count_x;
   logic [CntXW-1:0]   count_wide;
   logic               rsp_free;

   assign left_pos  = {pos_ff, 1'b0};
   assign right_pos = {pos_ff, 1'b1};
   assign count_x   = {1'b0, count_ff};
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign count_wide = CntXW'(count_ff);

   always_comb begin
      cmp_a = rd_data_ff;
      cmp_b = moving_ff;
      unique case (state_ff)
         S_UP_CMP: begin
            cmp_a = moving_ff;
            cmp_b = rd_data_ff;
         end
         S_DN_CMP: begin
            cmp_b = cand_ff;
         end
         default: begin
         end
      endcase
   end

   assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      moving_in   = moving_ff;
      cand_in     = cand_ff;
      left_win_in = left_win_ff;
      status_in   = status_ff;
      removed_in  = removed_ff;
      rd_addr     = Root;
      wr_en       = 1'b0;
      wr_addr     = pos_ff;
      wr_data     = moving_ff;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_count_in   = rsp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in  = ST_OK;
               removed_in = '0;
               moving_in  = req_value;
               if (req_operation == OP_INSERT) begin
                  if (count_ff == Cap) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     count_in = count_ff + AW'(1);
                     pos_in   = count_ff + AW'(1);
                     state_in = (count_ff == '0) ? S_FIN_WR : S_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     rd_addr  = Root;
                     state_in = S_RM_LAST;
                  end
               end
            end
         end
         S_UP_RD: begin
            rd_addr  = pos_ff >> 1;
            state_in = S_UP_CMP;
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (cmp_gt) begin
               // parent moves down into the hole
               wr_data  = rd_data_ff;
               pos_in   = pos_ff >> 1;
               state_in = ((pos_ff >> 1) == Root) ? S_FIN_WR : S_UP_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FIN_WR: begin
            wr_en    = 1'b1;
            state_in = S_DONE;
         end
         S_RM_LAST: begin
            removed_in = rd_data_ff;
            rd_addr    = count_ff;
            state_in   = S_RM_SET;
         end
         S_RM_SET: begin
            moving_in = rd_data_ff;
            count_in  = count_ff - AW'(1);
            pos_in    = Root;
            priority if (count_ff == Root) begin
               state_in = S_DONE;
            end else if (count_ff == AW'(2)) begin
               state_in = S_FIN_WR;
            end else begin
               state_in = S_DN_RDL;
            end
         end
         S_DN_RDL: begin
            if (left_pos > count_x) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               rd_addr  = left_pos[AW-1:0];
               state_in = S_DN_RDR;
            end
         end
         S_DN_RDR: begin
            cand_in     = cmp_gt ? rd_data_ff : moving_ff;
            left_win_in = cmp_gt;
            if (left_pos < count_x) begin
               rd_addr  = right_pos[AW-1:0];
               state_in = S_DN_CMP;
            end else begin
               // only a left child
               wr_en = 1'b1;
               if (cmp_gt) begin
                  wr_data  = rd_data_ff;
                  pos_in   = left_pos[AW-1:0];
                  state_in = S_DN_RDL;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            priority if (cmp_gt) begin
               wr_data  = rd_data_ff;
               pos_in   = right_pos[AW-1:0];
               state_in = S_DN_RDL;
            end else if (left_win_ff) begin
               wr_data  = cand_ff;
               pos_in   = left_pos[AW-1:0];
               state_in = S_DN_RDL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_removed_in = removed_ff;
               rsp_count_in   = count_wide[COUNT_W-1:0];
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= heap_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      moving_ff      <= moving_in;
      cand_ff        <= cand_in;
      left_win_ff    <= left_win_in;
      status_ff      <= status_in;
      removed_ff     <= removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_entry_count   = rsp_count_ff;

endmodule

>>> src/mhpq_checker.sv
// Port-level checks for the max-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and max_heap_priority_queue.
module mhpq_checker #(
   parameter int CAPACITY = 127
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input mhpq_pkg::status_type                rsp_status,
   input logic signed [mhpq_pkg::VALUE_W-1:0] rsp_removed_value,
   input logic        [mhpq_pkg::COUNT_W-1:0] rsp_entry_count
);
   import mhpq_pkg::*;

   localparam logic [COUNT_W-1:0] CapLow = COUNT_W'(CAPACITY % (1 << COUNT_W));

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_FULL || rsp_status == ST_EMPTY))
      else $error("result status code out of range");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_removed_value == '0))
      else $error("failed request returned a value");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_entry_count == CapLow))
      else $error("full status with count below capacity");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_entry_count == '0))
      else $error("empty status with entries held");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)
                                    && $stable(rsp_removed_value)
                                    && $stable(rsp_entry_count)))
      else $error("stalled result changed");

endmodule

bind max_heap_priority_queue mhpq_checker #(.CAPACITY(CAPACITY)) u_mhpq_checker (.*);
